[sv/oorq_pkg.sv]
// Shared constants, command/status structs and record types for the report queue.
`timescale 1ns / 1ps
package oorq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int MAX_PAYLOAD = 31;
	localparam int CHUNK_SLOTS = (MAX_PAYLOAD + 7) / 8;

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(2 * QUEUE_DEPTH);
	localparam int IDX_W  = $clog2(CHUNK_SLOTS + 1);
	localparam int KW     = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
	localparam int PAY_AW = $clog2(QUEUE_DEPTH * CHUNK_SLOTS);
	localparam int ROOM_W = $clog2(CHUNK_SLOTS * 8 + 8);
	localparam int SIZE_W = 5;

	localparam logic       CMD_PUSH        = 1'b0;
	localparam logic       CMD_POP         = 1'b1;
	localparam logic [7:0] RSSI_UNMEASURED = 8'h7F;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_SEND  = 3'b100
	} state_t;

	typedef struct packed {
		logic push_en;
		logic pop_start;
		logic load_empty;
		logic load_out;
		logic next_word;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic out_last;
	} dp_sts_t;

	typedef struct packed {
		logic [47:0]       addr;
		logic              rssi_valid;
		logic [7:0]        rssi;
		logic [SIZE_W-1:0] size;
		logic [31:0]       time_ms;
	} meta_t;

	typedef struct packed {
		logic              any;
		logic [47:0]       addr;
		logic              rssi_valid;
		logic [7:0]        rssi;
		logic [SIZE_W-1:0] size;
		logic [31:0]       time_ms;
		logic [63:0]       chunk;
		logic              last;
		logic [31:0]       missed;
	} result_t;

endpackage

[sv/oorq_ctrl.sv]
// Controller state machine: sequences pushes and the word-by-word readout of a pop.
`timescale 1ns / 1ps
module oorq_ctrl
	import oorq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_cmd,
	output logic    in_ready,
	input  logic    out_ready,
	output logic    out_valid,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t st_q, st_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		st_nxt    = st_q;
		in_ready  = (st_q == ST_IDLE);
		out_valid = (st_q == ST_SEND);
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_PUSH) begin
						cmd.push_en = 1'b1;
					end else if (sts.empty) begin
						cmd.load_empty = 1'b1;
						st_nxt         = ST_SEND;
					end else begin
						cmd.pop_start = 1'b1;
						st_nxt        = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				// memory read data is valid now
				cmd.load_out = 1'b1;
				st_nxt       = ST_SEND;
			end
			ST_SEND: begin
				if (out_ready) begin
					if (sts.out_last) begin
						st_nxt = ST_IDLE;
					end else begin
						cmd.next_word = 1'b1;
						st_nxt        = ST_FETCH;
					end
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

endmodule

[sv/oorq_datapath.sv]
// Datapath: ring pointers, drop counter, record and payload memories, result register.
`timescale 1ns / 1ps
module oorq_datapath
	import oorq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [47:0] in_address,
	input  logic [7:0]  in_rssi,
	input  logic [7:0]  in_length,
	input  logic [31:0] in_time_ms,
	input  logic [63:0] in_chunk,
	input  logic        in_last,
	output result_t     res
);

	logic [CNT_W-1:0] wr_cnt_q, rd_cnt_q;
	logic [31:0]      drop_q;
	logic [IDX_W-1:0] idx_q;

	meta_t            pend_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [KW-1:0]    k_q;
	meta_t            meta_rd_q;
	logic [63:0]      pay_rd_q;
	result_t          res_q;

	meta_t            meta_mem [QUEUE_DEPTH];
	logic [63:0]      pay_mem  [QUEUE_DEPTH * CHUNK_SLOTS];

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_W'(2 * QUEUE_DEPTH - 1)) ? '0 : c + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] s;
		s = (c >= CNT_W'(QUEUE_DEPTH)) ? c - CNT_W'(QUEUE_DEPTH) : c;
		return s[SLOT_W-1:0];
	endfunction

	logic [CNT_W:0]    diff;
	logic [CNT_W:0]    occ_w;
	logic [CNT_W-1:0]  occ;
	logic              full;
	logic [SLOT_W-1:0] wslot, rslot_now;

	assign diff      = {1'b0, wr_cnt_q} - {1'b0, rd_cnt_q};
	assign occ_w     = diff[CNT_W] ? diff + (CNT_W + 1)'(2 * QUEUE_DEPTH) : diff;
	assign occ       = occ_w[CNT_W-1:0];
	assign full      = (occ >= CNT_W'(QUEUE_DEPTH));
	assign wslot     = slot_of(wr_cnt_q);
	assign rslot_now = slot_of(rd_cnt_q);

	// push side
	logic              first;
	logic [SIZE_W-1:0] len_clamp;
	meta_t             cur_meta, fin_meta;
	logic              has_room;
	logic [IDX_W-1:0]  words_now;
	logic [ROOM_W-1:0] room;
	logic              pay_we, meta_we;
	logic [PAY_AW-1:0] pay_waddr;

	always_comb begin
		first     = (idx_q == '0);
		len_clamp = (in_length > 8'(MAX_PAYLOAD)) ? SIZE_W'(MAX_PAYLOAD)
		                                          : SIZE_W'(in_length);
		if (first) begin
			cur_meta.addr       = in_address;
			cur_meta.rssi_valid = (in_rssi != RSSI_UNMEASURED);
			cur_meta.rssi       = in_rssi;
			cur_meta.size       = len_clamp;
			cur_meta.time_ms    = in_time_ms;
		end else begin
			cur_meta = pend_q;
		end
		has_room  = (idx_q < IDX_W'(CHUNK_SLOTS));
		words_now = has_room ? idx_q + 1'b1 : idx_q;
		room      = ROOM_W'(words_now) << 3;
		fin_meta  = cur_meta;
		// short record: never report bytes that no word filled
		if (ROOM_W'(cur_meta.size) > room) begin
			fin_meta.size = SIZE_W'(room);
		end
		pay_we    = cmd.push_en && has_room;
		meta_we   = cmd.push_en && in_last;
		pay_waddr = PAY_AW'(wslot) * PAY_AW'(CHUNK_SLOTS) + PAY_AW'(idx_q);
	end

	// pop side
	logic              pay_re;
	logic [PAY_AW-1:0] pay_raddr;
	logic [KW-1:0]     k_nxt;

	always_comb begin
		k_nxt  = k_q + 1'b1;
		pay_re = cmd.pop_start || cmd.next_word;
		if (cmd.pop_start) begin
			pay_raddr = PAY_AW'(rslot_now) * PAY_AW'(CHUNK_SLOTS);
		end else begin
			pay_raddr = PAY_AW'(rslot_q) * PAY_AW'(CHUNK_SLOTS) + PAY_AW'(k_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q <= '0;
			rd_cnt_q <= '0;
			drop_q   <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.push_en) begin
				if (first && full) begin
					drop_q   <= drop_q + 32'd1;
					rd_cnt_q <= bump(rd_cnt_q);
				end
				if (in_last) begin
					wr_cnt_q <= bump(wr_cnt_q);
					idx_q    <= '0;
				end else begin
					idx_q    <= words_now;
				end
			end else if (cmd.pop_start) begin
				rd_cnt_q <= bump(rd_cnt_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_en && first) begin
			pend_q <= cur_meta;
		end
		if (meta_we) begin
			meta_mem[wslot] <= fin_meta;
		end
		if (pay_we) begin
			pay_mem[pay_waddr] <= in_chunk;
		end
		if (cmd.pop_start) begin
			meta_rd_q <= meta_mem[rslot_now];
			rslot_q   <= rslot_now;
			k_q       <= '0;
		end else if (cmd.next_word) begin
			k_q       <= k_nxt;
		end
		if (pay_re) begin
			pay_rd_q <= pay_mem[pay_raddr];
		end
	end

	// result formatting from registered memory data
	logic [IDX_W-1:0]  words_rd;
	logic [ROOM_W-1:0] pos;
	logic [63:0]       word_masked;
	logic              last_rd;

	always_comb begin
		words_rd = (meta_rd_q.size == '0) ? IDX_W'(1)
		         : IDX_W'((ROOM_W'(meta_rd_q.size) + ROOM_W'(7)) >> 3);
		last_rd  = ((IDX_W'(k_q) + 1'b1) == words_rd);
		for (int b = 0; b < 8; b++) begin
			pos = (ROOM_W'(k_q) << 3) + ROOM_W'(b);
			word_masked[b*8 +: 8] = (pos < ROOM_W'(meta_rd_q.size)) ? pay_rd_q[b*8 +: 8]
			                                                        : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_empty) begin
			res_q <= '{1'b0, 48'h0, 1'b0, 8'h00, SIZE_W'(0), 32'h0, 64'h0, 1'b1, drop_q};
		end else if (cmd.load_out) begin
			res_q.any        <= 1'b1;
			res_q.addr       <= meta_rd_q.addr;
			res_q.rssi_valid <= meta_rd_q.rssi_valid;
			res_q.rssi       <= meta_rd_q.rssi;
			res_q.size       <= meta_rd_q.size;
			res_q.time_ms    <= meta_rd_q.time_ms;
			res_q.chunk      <= word_masked;
			res_q.last       <= last_rd;
			res_q.missed     <= drop_q;
		end
	end

	assign res          = res_q;
	assign sts.empty    = (wr_cnt_q == rd_cnt_q);
	assign sts.out_last = res_q.last;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= CNT_W'(QUEUE_DEPTH))
		else $error("ring occupancy above depth");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(CHUNK_SLOTS))
		else $error("chunk index past payload slots");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_start |-> !sts.empty)
		else $error("record read started on empty ring");

	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_start || cmd.next_word) |=> cmd.load_out)
		else $error("memory read not followed by result load");

endmodule

[sv/overwrite_oldest_report_queue_core.sv]
// Top level of the overwrite-oldest report queue: stream ports, controller and datapath.
`timescale 1ns / 1ps
// Overwrite-oldest queue of radio sighting records, 32 records of up to 31 bytes.
// Slave stream: tuser = command (0 push one payload word, 1 pop the oldest
// record). A push carries address, raw strength, length, time and one 64-bit
// word in tdata, tlast on the final word commits the record. Metadata is taken
// on the first word; a full ring drops its oldest record then and bumps the
// miss counter. A push transfer gives no result.
// Master stream: a pop yields one transfer per payload word (tlast on the
// final one), or a single empty transfer with tuser (any) = 0.
// The first word of a pop passes through the registered read of the payload
// memory and then the result register (an empty ring loads the result
// register directly); each further word is read the same way once the
// previous one is taken.
// While a pop is being delivered the slave side is not ready; a stalled
// receiver simply holds the result register and the block waits.
// Reset clears the ring pointers, word index and miss counter; the ring is
// empty afterwards and no clearing pass is needed.
module overwrite_oldest_report_queue_core
	import oorq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [47:0] address, [55:48] raw_rssi, [63:56] data_length, [95:64] time_ms,
	// [159:96] chunk
	input  logic [159:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	// [0] command
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [47:0] out_address, [48] rssi_valid, [56:49] rssi, [61:57] size,
	// [93:62] out_time_ms, [157:94] out_chunk, [189:158] missed, [191:190] zero
	output logic [191:0] m_axis_tdata,
	output logic         m_axis_tlast,
	// [0] any
	output logic         m_axis_tuser
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	result_t res;

	oorq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.sts       (sts),
		.cmd       (cmd)
	);

	oorq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_address (s_axis_tdata[47:0]),
		.in_rssi    (s_axis_tdata[55:48]),
		.in_length  (s_axis_tdata[63:56]),
		.in_time_ms (s_axis_tdata[95:64]),
		.in_chunk   (s_axis_tdata[159:96]),
		.in_last    (s_axis_tlast),
		.res        (res)
	);

	assign m_axis_tdata = {2'b00, res.missed, res.chunk, res.time_ms, res.size,
	                       res.rssi, res.rssi_valid, res.addr};
	assign m_axis_tlast = res.last;
	assign m_axis_tuser = res.any;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the overwrite-oldest report queue core.
`timescale 1ns / 1ps
module tb_top;
	import oorq_pkg::*;

	localparam int COUNT_WRAP   = 2 * QUEUE_DEPTH;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 220;

	// one slave-side transfer, split into its fields
	typedef struct packed {
		logic        cmd;
		logic [47:0] addr;
		logic [7:0]  rssi;
		logic [7:0]  len;
		logic [31:0] stamp;
		logic [63:0] chunk;
		logic        last;
	} sighting_t;

	typedef struct packed {
		sighting_t item;
		logic      typed;
		result_t   want;
	} stim_row_t;

	localparam result_t NO_CHECK = '0;
	localparam result_t EMPTY_REPORT =
		'{1'b0, 48'h0, 1'b0, 8'h00, 5'd0, 32'h0, 64'h0, 1'b1, 32'h0};
	localparam result_t ZERO_LENGTH_REPORT =
		'{1'b1, 48'hFFFF_FFFF_FFFF, 1'b0, 8'h7F, 5'd0, 32'hFFFF_FFFF, 64'h0, 1'b1, 32'h0};
	localparam result_t SHORT_REPORT =
		'{1'b1, 48'h0, 1'b1, 8'h80, 5'd8, 32'h0, 64'h0123_4567_89AB_CDEF, 1'b1, 32'h0};
	localparam sighting_t POP_PLAIN = '{CMD_POP, 48'h0, 8'h00, 8'h00, 32'h0, 64'h0, 1'b0};
	localparam sighting_t POP_NOISE = '{CMD_POP, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF,
		32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1};

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;
	logic         s_axis_tlast;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [191:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         m_axis_tuser;

	// shadow of the ring
	logic [47:0] ring_addr [QUEUE_DEPTH];
	logic [7:0]  ring_rssi [QUEUE_DEPTH];
	logic [5:0]  ring_size [QUEUE_DEPTH];
	logic [31:0] ring_stamp [QUEUE_DEPTH];
	logic [63:0] ring_words [QUEUE_DEPTH][CHUNK_SLOTS];
	int unsigned wr_count;
	int unsigned rd_count;
	int unsigned words_in;
	logic [31:0] dropped;

	result_t step_reports [$];
	result_t reports_due [$];
	int      mismatches;
	int      items_sent;
	int      cycle_count;
	logic    hold_request;
	logic    sender_calm;
	int      calm_left;

	stim_row_t directed_rows [25] = '{
		'{POP_PLAIN, 1'b1, EMPTY_REPORT},
		'{'{CMD_PUSH, 48'hFFFF_FFFF_FFFF, 8'h7F, 8'd0, 32'hFFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
		'{POP_NOISE, 1'b1, ZERO_LENGTH_REPORT},
		'{'{CMD_PUSH, 48'h0, 8'h80, 8'hFF, 32'h0, 64'h0123_4567_89AB_CDEF, 1'b1},
			1'b0, NO_CHECK},
		'{POP_PLAIN, 1'b1, SHORT_REPORT},
		'{'{CMD_PUSH, 48'h5A5A_0000_A5A5, 8'h7E, 8'd31, 32'h8000_0001,
			64'h1111_2222_3333_4444, 1'b0}, 1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h0, 8'h00, 8'd0, 32'h0, 64'h5555_6666_7777_8888, 1'b0},
			1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h0, 8'h00, 8'd0, 32'h0, 64'h9999_AAAA_BBBB_CCCC, 1'b0},
			1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h0, 8'h00, 8'd0, 32'h0, 64'hDDDD_EEEE_FFFF_0000, 1'b1},
			1'b0, NO_CHECK},
		// first word of a record left open across the next two pops
		'{'{CMD_PUSH, 48'h8000_0000_0001, 8'h01, 8'd20, 32'h7FFF_FFFF,
			64'hAAAA_AAAA_AAAA_AAAA, 1'b0}, 1'b0, NO_CHECK},
		'{POP_NOISE, 1'b0, NO_CHECK},
		'{POP_PLAIN, 1'b1, EMPTY_REPORT},
		'{'{CMD_PUSH, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
			64'h5555_5555_5555_5555, 1'b0}, 1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h0, 8'h00, 8'd0, 32'h0, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0},
			1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h0, 8'h00, 8'd0, 32'h0, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0},
			1'b0, NO_CHECK},
		// fifth word: beyond the slot, only commits
		'{'{CMD_PUSH, 48'h0, 8'h00, 8'd0, 32'h0, 64'h1234_5678_9ABC_DEF0, 1'b1},
			1'b0, NO_CHECK},
		'{POP_PLAIN, 1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h0000_FFFF_0000, 8'hFF, 8'd13, 32'h0000_FFFF,
			64'h0102_0304_0506_0708, 1'b0}, 1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h0, 8'h00, 8'd0, 32'h0, 64'h1112_1314_1516_1718, 1'b1},
			1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h7FFF_FFFF_FFFF, 8'h81, 8'd200, 32'hFFFF_0000,
			64'hCAFE_F00D_DEAD_BEEF, 1'b0}, 1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h0, 8'h00, 8'd0, 32'h0, 64'h8888_7777_6666_5555, 1'b0},
			1'b0, NO_CHECK},
		'{'{CMD_PUSH, 48'h0, 8'h00, 8'd0, 32'h0, 64'h4444_3333_2222_1111, 1'b1},
			1'b0, NO_CHECK},
		'{POP_NOISE, 1'b0, NO_CHECK},
		'{POP_PLAIN, 1'b0, NO_CHECK},
		'{POP_NOISE, 1'b1, EMPTY_REPORT}
	};

	overwrite_oldest_report_queue_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
		end
	endtask

	// advances the shadow ring by one accepted transfer, leaves the reports in step_reports
	task automatic predict_sighting(input sighting_t s);
		int unsigned slot;
		int unsigned size;
		int unsigned nwords;
		int unsigned rem;
		int unsigned occ;
		logic [63:0] word;
		result_t     r;
		step_reports.delete();
		occ = (wr_count + COUNT_WRAP - rd_count) % COUNT_WRAP;
		if (s.cmd == CMD_PUSH) begin
			slot = wr_count % QUEUE_DEPTH;
			if (words_in == 0) begin
				if (occ >= QUEUE_DEPTH) begin
					dropped++;
					rd_count = (rd_count + 1) % COUNT_WRAP;
				end
				ring_addr[slot]  = s.addr;
				ring_rssi[slot]  = s.rssi;
				ring_size[slot]  = (s.len > MAX_PAYLOAD) ? 6'(MAX_PAYLOAD) : 6'(s.len);
				ring_stamp[slot] = s.stamp;
			end
			if (words_in < CHUNK_SLOTS) begin
				ring_words[slot][words_in] = s.chunk;
				words_in++;
			end
			if (s.last) begin
				if (ring_size[slot] > words_in * 8) begin
					ring_size[slot] = 6'(words_in * 8);
				end
				wr_count = (wr_count + 1) % COUNT_WRAP;
				words_in = 0;
			end
		end else if (occ == 0) begin
			r = '0;
			r.last = 1'b1;
			r.missed = dropped;
			step_reports.push_back(r);
		end else begin
			slot = rd_count % QUEUE_DEPTH;
			size = ring_size[slot];
			nwords = (size == 0) ? 1 : (size + 7) / 8;
			for (int unsigned k = 0; k < nwords; k++) begin
				word = '0;
				if (size > k * 8) begin
					rem = size - k * 8;
					word = ring_words[slot][k];
					// bytes past the stored length read as zero
					if (rem < 8) begin
						word &= (64'd1 << (8 * rem)) - 64'd1;
					end
				end
				r.any        = 1'b1;
				r.addr       = ring_addr[slot];
				r.rssi_valid = ring_rssi[slot] != RSSI_UNMEASURED;
				r.rssi       = ring_rssi[slot];
				r.size       = SIZE_W'(size);
				r.time_ms    = ring_stamp[slot];
				r.chunk      = word;
				r.last       = k + 1 == nwords;
				r.missed     = dropped;
				step_reports.push_back(r);
			end
			rd_count = (rd_count + 1) % COUNT_WRAP;
		end
	endtask

	function automatic sighting_t random_sighting(input logic cmd);
		sighting_t s;
		s.cmd   = cmd;
		s.addr  = 48'({$urandom, $urandom});
		s.rssi  = ($urandom_range(0, 5) == 0) ? RSSI_UNMEASURED : 8'($urandom);
		s.len   = 8'($urandom);
		s.stamp = $urandom;
		s.chunk = {$urandom, $urandom};
		s.last  = 1'($urandom);
		return s;
	endfunction

	// drives one item after a random gap and holds it until the transfer
	task automatic offer(input sighting_t s, input logic typed = 1'b0,
			input result_t want = '0);
		int gap;
		int roll;
		if (calm_left == 0) begin
			sender_calm = $urandom_range(0, 3) == 0;
			calm_left = $urandom_range(10, 60);
		end
		calm_left--;
		roll = $urandom_range(0, 99);
		if (sender_calm || roll < 60) begin
			gap = 0;
		end else if (roll < 92) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 40);
		end
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {s.chunk, s.stamp, s.len, s.rssi, s.addr};
		s_axis_tlast  <= s.last;
		s_axis_tuser  <= s.cmd;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		items_sent++;
		predict_sighting(s);
		if (typed) begin
			reports_due.push_back(want);
		end else begin
			foreach (step_reports[i]) reports_due.push_back(step_reports[i]);
		end
	endtask

	task automatic offer_pop;
		offer(random_sighting(CMD_POP));
	endtask

	// metadata on later words is junk the block must ignore
	task automatic offer_record(input int nwords, input logic [7:0] len,
			input logic may_interleave);
		sighting_t s;
		logic [7:0] rssi;
		rssi = ($urandom_range(0, 5) == 0) ? RSSI_UNMEASURED : 8'($urandom);
		for (int w = 0; w < nwords; w++) begin
			if (w != 0 && may_interleave && $urandom_range(0, 9) == 0) begin
				offer_pop();
			end
			s = random_sighting(CMD_PUSH);
			if (w == 0) begin
				s.len = len;
				s.rssi = rssi;
			end
			s.last = w == nwords - 1;
			offer(s);
		end
	endtask

	task automatic wait_drained;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver: random readiness, calm stretches, one long hold on request
	initial begin
		int stretch_left;
		logic calm;
		m_axis_tready = 1'b0;
		stretch_left = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stretch_left == 0) begin
				calm = $urandom_range(0, 3) == 0;
				stretch_left = $urandom_range(20, 200);
			end
			stretch_left--;
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (!calm && $urandom_range(0, 29) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) < 65);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.any        = m_axis_tuser;
			got.addr       = m_axis_tdata[47:0];
			got.rssi_valid = m_axis_tdata[48];
			got.rssi       = m_axis_tdata[56:49];
			got.size       = m_axis_tdata[61:57];
			got.time_ms    = m_axis_tdata[93:62];
			got.chunk      = m_axis_tdata[157:94];
			got.last       = m_axis_tlast;
			got.missed     = m_axis_tdata[189:158];
			if (reports_due.size() == 0) begin
				report_mismatch($sformatf("transfer with nothing pending: %h", got));
			end else begin
				want = reports_due.pop_front();
				check_field("any", 64'(got.any), 64'(want.any));
				check_field("address", 64'(got.addr), 64'(want.addr));
				check_field("rssi_valid", 64'(got.rssi_valid), 64'(want.rssi_valid));
				check_field("rssi", 64'(got.rssi), 64'(want.rssi));
				check_field("size", 64'(got.size), 64'(want.size));
				check_field("time_ms", 64'(got.time_ms), 64'(want.time_ms));
				check_field("chunk", got.chunk, want.chunk);
				check_field("last", 64'(got.last), 64'(want.last));
				check_field("missed", 64'(got.missed), 64'(want.missed));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int start;
		int roll;
		int nwords;
		int full;
		logic [7:0] len;
		logic paused;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		s_axis_tuser  = CMD_PUSH;
		hold_request  = 1'b0;
		sender_calm   = 1'b0;
		calm_left     = 0;
		mismatches    = 0;
		items_sent    = 0;
		wr_count      = 0;
		rd_count      = 0;
		words_in      = 0;
		dropped       = '0;
		paused        = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		end
		wait_drained();

		// long receiver hold while full records and pops keep coming
		hold_request = 1'b1;
		repeat (6) begin
			offer_record(CHUNK_SLOTS, 8'(MAX_PAYLOAD), 1'b0);
			offer_pop();
		end
		wait_drained();

		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (!paused && items_sent - start >= RANDOM_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 62) begin
				if ($urandom_range(0, 9) != 0) begin
					nwords = $urandom_range(1, CHUNK_SLOTS);
				end else begin
					nwords = $urandom_range(CHUNK_SLOTS + 1, CHUNK_SLOTS + 2);
				end
				full = (nwords < CHUNK_SLOTS) ? nwords : CHUNK_SLOTS;
				if ($urandom_range(0, 4) == 0) begin
					len = 8'($urandom);
				end else begin
					len = 8'($urandom_range((full - 1) * 8,
						(full * 8 > MAX_PAYLOAD) ? MAX_PAYLOAD : full * 8));
				end
				offer_record(nwords, len, 1'b1);
			end else if (roll < 94) begin
				offer_pop();
			end else begin
				offer(random_sighting(CMD_PUSH));
			end
		end
		// empty the ring and read the miss count from empty pops
		repeat (QUEUE_DEPTH + 2) offer_pop();
		wait_drained();

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[overwrite_oldest_report_queue_core.f]
sv/oorq_pkg.sv
sv/oorq_ctrl.sv
sv/oorq_datapath.sv
sv/overwrite_oldest_report_queue_core.sv
sim/tb_top.sv
